### hdl/wla_pkg.sv
// shared types and constants for the wrapped local alignment unit
// used by every module of the block; no dependencies of its own

package wla_pkg;

  localparam int DEF_MAX_COLS    = 1024;
  localparam int DEF_MAX_ROWS    = 4096;
  localparam int DEF_SCORE_WIDTH = 16;

  // depth of the queue between the front and back halves
  localparam int QUEUE_DEPTH = 4;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [15:0] RST_ROW_GAP_OPEN   = -16'sd10;
  localparam logic signed [15:0] RST_ROW_GAP_EXTEND = -16'sd1;
  localparam logic signed [15:0] RST_COL_GAP_OPEN   = -16'sd10;
  localparam logic signed [15:0] RST_COL_GAP_EXTEND = -16'sd1;
  localparam logic [10:0]        RST_COLUMN_COUNT   = 11'd1024;

  typedef enum logic [2:0] {
    REG_ROW_GAP_OPEN   = 3'd0,
    REG_ROW_GAP_EXTEND = 3'd1,
    REG_COL_GAP_OPEN   = 3'd2,
    REG_COL_GAP_EXTEND = 3'd3,
    REG_COLUMN_COUNT   = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    TRACE_ZERO  = 2'd0,
    TRACE_INS   = 2'd1,
    TRACE_DEL   = 2'd2,
    TRACE_MATCH = 2'd3
  } trace_code_t;

  typedef struct packed {
    logic signed [15:0] row_gap_open;
    logic signed [15:0] row_gap_extend;
    logic signed [15:0] col_gap_open;
    logic signed [15:0] col_gap_extend;
    logic [10:0]        column_count;
  } cfg_t;

  typedef struct packed {
    logic signed [10:0] match_score;
    logic               first_cell;
  } in_item_t;

  typedef struct packed {
    trace_code_t trace_code;
    logic [14:0] cell_score;
    logic [14:0] best_score;
    logic [12:0] best_row;
    logic [10:0] best_col;
  } out_item_t;

endpackage

### hdl/wla_cfg.sv
// apb register bank: gap penalties and column count
// depends on wla_pkg; also exports the clipped column count

module wla_cfg #(
  parameter int MAX_COLS = wla_pkg::DEF_MAX_COLS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [wla_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [wla_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [wla_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output wla_pkg::cfg_t                   cfg,
  output logic [$clog2(MAX_COLS+1)-1:0]   cols
);
  import wla_pkg::*;

  localparam int CW  = $clog2(MAX_COLS + 1);
  localparam int CCW = (CW > 11) ? CW : 11;

  reg_idx_t idx;
  logic     wr_en;
  logic [CCW-1:0] cc_w;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_gap_open   <= RST_ROW_GAP_OPEN;
      cfg.row_gap_extend <= RST_ROW_GAP_EXTEND;
      cfg.col_gap_open   <= RST_COL_GAP_OPEN;
      cfg.col_gap_extend <= RST_COL_GAP_EXTEND;
      cfg.column_count   <= RST_COLUMN_COUNT;
    end else if (wr_en) begin
      unique case (idx)
        REG_ROW_GAP_OPEN:   cfg.row_gap_open   <= pwdata[15:0];
        REG_ROW_GAP_EXTEND: cfg.row_gap_extend <= pwdata[15:0];
        REG_COL_GAP_OPEN:   cfg.col_gap_open   <= pwdata[15:0];
        REG_COL_GAP_EXTEND: cfg.col_gap_extend <= pwdata[15:0];
        REG_COLUMN_COUNT:   cfg.column_count   <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ROW_GAP_OPEN:   prdata = {16'd0, cfg.row_gap_open};
      REG_ROW_GAP_EXTEND: prdata = {16'd0, cfg.row_gap_extend};
      REG_COL_GAP_OPEN:   prdata = {16'd0, cfg.col_gap_open};
      REG_COL_GAP_EXTEND: prdata = {16'd0, cfg.col_gap_extend};
      REG_COLUMN_COUNT:   prdata = {21'd0, cfg.column_count};
      default:            prdata = '0;
    endcase
  end

  // zero means one column, anything past the row buffer means all of it
  always_comb begin
    cc_w = CCW'(cfg.column_count);
    if (cc_w == '0) begin
      cols = CW'(1);
    end else if (cc_w > CCW'(MAX_COLS)) begin
      cols = CW'(MAX_COLS);
    end else begin
      cols = cc_w[CW-1:0];
    end
  end

endmodule

### hdl/wla_front.sv
// front half: accepts score items and assigns each its row and column
// depends on wla_pkg; feeds wla_queue

module wla_front #(
  parameter int MAX_COLS = wla_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = wla_pkg::DEF_MAX_ROWS,
  localparam int RW = $clog2(MAX_ROWS + 1),
  localparam int CW = $clog2(MAX_COLS + 1),
  localparam int EW = 11 + 1 + RW + CW
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  wla_pkg::in_item_t in_item,
  input  logic [CW-1:0]     cols,
  input  logic              q_full,
  output logic              push,
  output logic [EW-1:0]     push_data
);
  import wla_pkg::*;

  typedef struct packed {
    logic signed [10:0] ms;
    logic               new_matrix;
    logic [RW-1:0]      row;
    logic [CW-1:0]      col;
  } cell_t;

  logic [RW-1:0] row_counter, row_next;
  logic [CW-1:0] col_counter, col_next;
  logic [CW:0]   col_inc;
  logic          new_matrix;
  cell_t         ent;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    new_matrix = in_item.first_cell || (row_counter == '0);
    col_inc    = {1'b0, col_counter} + 1'b1;
    row_next   = row_counter;
    col_next   = col_inc[CW-1:0];
    if (new_matrix) begin
      row_next = RW'(1);
      col_next = CW'(1);
    end else if (col_inc > {1'b0, cols}) begin
      col_next = CW'(1);
      if (row_counter < RW'(MAX_ROWS)) begin
        row_next = row_counter + 1'b1;
      end
    end
    ent.ms         = in_item.match_score;
    ent.new_matrix = new_matrix;
    ent.row        = row_next;
    ent.col        = col_next;
  end

  assign push_data = ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter <= '0;
      col_counter <= '0;
    end else if (push) begin
      row_counter <= row_next;
      col_counter <= col_next;
    end
  end

endmodule

### hdl/wla_queue.sv
// small fifo between the front and back halves
// depends on wla_pkg for its default depth and the import convention

module wla_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = wla_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  output logic             q_valid,
  output logic [WIDTH-1:0] q_data,
  input  logic             pop
);
  import wla_pkg::*;

  localparam int PW  = $clog2(DEPTH);
  localparam int CNW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CNW-1:0]   count;

  assign full    = (count == CNW'(DEPTH));
  assign q_valid = (count != '0);
  assign q_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hdl/wla_back.sv
// back half: row buffer, affine-gap recurrence, best tracking, output register
// depends on wla_pkg; takes cells from wla_queue

module wla_back #(
  parameter int MAX_COLS    = wla_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS    = wla_pkg::DEF_MAX_ROWS,
  parameter int SCORE_WIDTH = wla_pkg::DEF_SCORE_WIDTH,
  localparam int RW = $clog2(MAX_ROWS + 1),
  localparam int CW = $clog2(MAX_COLS + 1),
  localparam int EW = 11 + 1 + RW + CW
) (
  input  logic               clk,
  input  logic               rst,
  input  wla_pkg::cfg_t      cfg,
  input  logic [CW-1:0]      cols,
  input  logic               q_valid,
  input  logic [EW-1:0]      q_data,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output wla_pkg::out_item_t out_item
);
  import wla_pkg::*;

  localparam int SW  = SCORE_WIDTH;
  localparam int AW  = ((SW > 16) ? SW : 16) + 2;
  localparam int ADW = $clog2(MAX_COLS);
  localparam logic signed [AW-1:0] SC_MAX = AW'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [AW-1:0] SC_MIN = AW'(-(64'sd1 <<< (SW - 1)));

  typedef struct packed {
    logic signed [10:0] ms;
    logic               new_matrix;
    logic [RW-1:0]      row;
    logic [CW-1:0]      col;
  } cell_t;

  typedef struct packed {
    logic signed [SW-1:0] score;
    logic signed [SW-1:0] vgap;
  } row_ent_t;

  function automatic logic signed [SW-1:0] sat_fn(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] r;
    r = v;
    if (v > SC_MAX) r = SC_MAX;
    if (v < SC_MIN) r = SC_MIN;
    return r[SW-1:0];
  endfunction

  function automatic logic [14:0] clip15(input logic signed [SW-1:0] v);
    logic signed [32:0] w;
    logic [14:0]        r;
    w = 33'(v);
    if (w < 0) r = '0;
    else if (w > 33'sd32767) r = 15'h7fff;
    else r = w[14:0];
    return r;
  endfunction

  row_ent_t row_mem [MAX_COLS];

  cell_t    q_cell, c_cell;
  logic     c_valid, fire;
  row_ent_t rd_above, rd_wrap, byp_ent, wr_ent, above_ent;
  logic     byp_above, byp_wrap;
  logic [CW-1:0]  q_col_m1, c_col_m1, cols_m1;
  logic [ADW-1:0] rd_addr, wr_addr, cols_addr;

  logic signed [SW-1:0] left_score, left_gap, diagonal_score, best_value;
  logic [RW-1:0] best_row_pos;
  logic [CW-1:0] best_col_pos;

  logic                 row_one, col_one;
  logic signed [SW-1:0] score_cols, wrap, left_eff, diag_eff, above_sc;
  logic signed [AW-1:0] lgap_eff, above_w, agap_w, e1, e0, d1, d0, m_w;
  logic signed [SW-1:0] e, d, m, cmax, c;
  trace_code_t          code;
  logic signed [SW-1:0] best_eff, best_value_next;
  logic [RW-1:0]        best_row_next;
  logic [CW-1:0]        best_col_next;

  assign q_cell = q_data;
  assign fire   = c_valid && (!out_valid || !out_stall);
  assign pop    = q_valid && (!c_valid || fire);

  assign q_col_m1  = q_cell.col - 1'b1;
  assign c_col_m1  = c_cell.col - 1'b1;
  assign cols_m1   = cols - 1'b1;
  assign rd_addr   = q_col_m1[ADW-1:0];
  assign wr_addr   = c_col_m1[ADW-1:0];
  assign cols_addr = cols_m1[ADW-1:0];

  // row buffer: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (fire) begin
      row_mem[wr_addr] <= wr_ent;
    end
    if (pop) begin
      rd_above <= row_mem[rd_addr];
      rd_wrap  <= row_mem[cols_addr];
    end
  end

  // the cell finishing now may write what the next cell reads
  always_ff @(posedge clk) begin
    if (pop) begin
      byp_above <= fire && (wr_addr == rd_addr);
      byp_wrap  <= fire && (wr_addr == cols_addr);
      byp_ent   <= wr_ent;
      c_cell    <= q_cell;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (pop) begin
      c_valid <= 1'b1;
    end else if (fire) begin
      c_valid <= 1'b0;
    end
  end

  always_comb begin
    above_ent  = byp_above ? byp_ent : rd_above;
    score_cols = byp_wrap ? byp_ent.score : rd_wrap.score;
    row_one    = (c_cell.row == RW'(1));
    col_one    = (c_cell.col == CW'(1));

    // wrap rule: last column of the row above carries into column zero
    wrap = '0;
    if (!row_one && (score_cols > 0)) begin
      wrap = score_cols;
    end
    left_eff = col_one ? wrap : left_score;
    diag_eff = col_one ? wrap : diagonal_score;
    lgap_eff = col_one ? AW'(cfg.col_gap_open) : AW'(left_gap);

    above_sc = row_one ? '0 : above_ent.score;
    above_w  = AW'(above_sc);
    agap_w   = row_one ? AW'(cfg.row_gap_open) : AW'(above_ent.vgap);

    e1  = AW'(left_eff) + AW'(cfg.col_gap_open) + AW'(cfg.col_gap_extend);
    e0  = lgap_eff + AW'(cfg.col_gap_extend);
    e   = sat_fn((e1 > e0) ? e1 : e0);
    d1  = above_w + AW'(cfg.row_gap_open) + AW'(cfg.row_gap_extend);
    d0  = agap_w + AW'(cfg.row_gap_extend);
    d   = sat_fn((d1 > d0) ? d1 : d0);
    m_w = AW'(diag_eff) + AW'(c_cell.ms);
    m   = sat_fn(m_w);

    cmax = m;
    if (e > cmax) cmax = e;
    if (d > cmax) cmax = d;

    c = cmax;
    if (cmax <= 0) begin
      c    = '0;
      code = TRACE_ZERO;
    end else if (cmax == d) begin
      code = TRACE_INS;
    end else if (cmax == e) begin
      code = TRACE_DEL;
    end else begin
      code = TRACE_MATCH;
    end

    wr_ent.score = c;
    wr_ent.vgap  = d;

    best_eff        = c_cell.new_matrix ? '0 : best_value;
    best_value_next = best_eff;
    best_row_next   = c_cell.new_matrix ? '0 : best_row_pos;
    best_col_next   = c_cell.new_matrix ? '0 : best_col_pos;
    if (c > best_eff) begin
      best_value_next = c;
      best_row_next   = c_cell.row;
      best_col_next   = c_cell.col;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      diagonal_score      <= above_sc;
      left_score          <= c;
      left_gap            <= e;
      best_value          <= best_value_next;
      best_row_pos        <= best_row_next;
      best_col_pos        <= best_col_next;
      out_item.trace_code <= code;
      out_item.cell_score <= clip15(c);
      out_item.best_score <= clip15(best_value_next);
      out_item.best_row   <= 13'(best_row_next);
      out_item.best_col   <= 11'(best_col_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### hdl/wrapped_local_alignment_affine_unit.sv
// top level of the wrapped local alignment unit with affine gaps
// depends on wla_pkg, wla_cfg, wla_front, wla_queue and wla_back
//
// usage:
//   in channel (in_valid / in_stall / in_item): one substitution score per
//   matrix cell, row-major; first_cell starts a new matrix at row 1, column 1.
//   out channel (out_valid / out_stall / out_item): one result per cell, in
//   order: trace code, cell score, best score so far and its position.
//   apb port: gap penalties and column count at byte address 4*index; write
//   only while no cell is in flight.
// timing:
//   one cell per cycle sustained while out_stall is low; a cell passes the
//   queue, the compute stage and the output register. the rate is set by
//   the left-score loop through the single compute stage of the back half;
//   the row buffer is a two-read, one-write memory of MAX_COLS entries with
//   registered reads. a stalled result holds in the output register while
//   the 4-entry queue keeps accepting; in_stall rises only once it is full.
// reset:
//   synchronous rst empties the queue and pipeline and restores register
//   defaults; the row buffer is not cleared, the first row of a matrix
//   does not use what it reads from it.

module wrapped_local_alignment_affine_unit #(
  parameter int MAX_COLS    = wla_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS    = wla_pkg::DEF_MAX_ROWS,
  parameter int SCORE_WIDTH = wla_pkg::DEF_SCORE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  wla_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output wla_pkg::out_item_t             out_item,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wla_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [wla_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [wla_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import wla_pkg::*;

  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int CW = $clog2(MAX_COLS + 1);
  localparam int EW = 11 + 1 + RW + CW;

  cfg_t          cfg;
  logic [CW-1:0] cols;
  logic          push, q_full, q_valid, pop;
  logic [EW-1:0] push_data, q_data;

  wla_cfg #(.MAX_COLS(MAX_COLS)) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .cols    (cols)
  );

  wla_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cols      (cols),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  wla_queue #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop)
  );

  wla_back #(
    .MAX_COLS    (MAX_COLS),
    .MAX_ROWS    (MAX_ROWS),
    .SCORE_WIDTH (SCORE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cols      (cols),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

### hdl/wla_checker.sv
// port-level checks for the wrapped local alignment unit, bound to the top
// depends on wla_pkg and wrapped_local_alignment_affine_unit

module wla_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input wla_pkg::out_item_t out_item
);
  import wla_pkg::*;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_best_covers_cell: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.best_score >= out_item.cell_score)
    else $error("best score below cell score");

  a_zero_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_item.trace_code == TRACE_ZERO) == (out_item.cell_score == 15'd0)))
    else $error("trace code and cell score disagree on zero");

  a_no_best_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.best_score == 15'd0)
      |-> (out_item.best_row == 13'd0) && (out_item.best_col == 11'd0))
    else $error("position reported without a best score");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");

endmodule

bind wrapped_local_alignment_affine_unit wla_checker u_wla_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
